[hw/rtl/rtdc_pkg.sv]
package rtdc_pkg;

  localparam int CODE_W    = 15;
  localparam int OHM_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = CFG_IDX_W'(1);

  localparam logic [OHM_W-1:0] REFERENCE_RESET = OHM_W'(6880);
  localparam logic [OHM_W-1:0] NOMINAL_RESET   = OHM_W'(1600);

  // ratio x = code * ref * 512 / nom, Q24
  localparam int PROD_W    = CODE_W + OHM_W;
  localparam int PRE_SHIFT = 9;
  localparam int NUM_W     = PROD_W + PRE_SHIFT;
  localparam int XQ_FRAC   = 24;

  // r = 100 * x in Q16
  localparam int RQ_SH  = 8;
  localparam int RQ_MUL = 100;
  localparam int R_W    = 26;

  // quadratic branch
  localparam logic [63:0] K_Q24  = (64'd39083 * 64'd39083) << XQ_FRAC;
  localparam logic [63:0] FOUR_B = 64'd231000000;
  localparam logic [63:0] Y_MAX  = K_Q24 / FOUR_B;
  localparam int Y_W    = 27;
  localparam int DQ_W   = 55;
  localparam int ROOT_W = 28;
  localparam logic [ROOT_W-1:0] A_Q12 = ROOT_W'(39083 * 4096);

  localparam int DEN_Q    = 231;
  localparam int DEN_SH   = 12;
  localparam int P_MUL    = 20;
  localparam int N_W      = ROOT_W + 6 + FRAC_BITS;
  localparam int M_W      = N_W - DEN_SH;
  localparam int MAG_K    = M_W;
  localparam int MAG_W    = MAG_K - 7;
  localparam logic [MAG_W-1:0] MAGIC = MAG_W'((64'd1 << MAG_K) / 64'd231);
  localparam logic [N_W-1:0] N_OFFSET = N_W'(DEN_Q) << (DEN_SH - 1);

  // polynomial branch, Horner in signed fixed point
  localparam int H_W    = 44;
  localparam int SUM_W  = 64;
  localparam int SPLIT  = 22;
  localparam int POLY_N = 5;
  localparam logic signed [H_W-1:0] POLY_C5 = H_W'(64'sd42905);
  localparam logic signed [H_W-1:0] POLY_C [POLY_N] = '{
    H_W'(-64'sd7932809),
    H_W'(-64'sd1358398237),
    H_W'(64'sd11106356),
    H_W'(64'sd37292396),
    H_W'(-64'sd4060421816)
  };
  localparam int POLY_SH [POLY_N] = '{16, 16, 32, 24, 16};
  localparam int ROUND_SH = XQ_FRAC - FRAC_BITS;
  localparam logic signed [H_W-1:0] ROUND_ADD = H_W'(64'sd1) <<< (ROUND_SH - 1);

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef struct packed {
    logic              valid;
    logic              hi;
    logic              qok;
    logic [Y_W-1:0]    y;
    logic [R_W-1:0]    r;
  } poly_side_t;

  typedef struct packed {
    logic              valid;
    logic              qok;
    logic [TEMP_W-1:0] poly_t;
    logic              poly_sat;
  } root_side_t;

endpackage

[hw/rtl/rtdc_div.sv]
module rtdc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rtdc_pkg::NUM_W-1:0] dividend,
  input  logic [rtdc_pkg::OHM_W-1:0] divisor,
  output logic                       out_valid,
  output logic [rtdc_pkg::NUM_W-1:0] quotient
);

  localparam int NW = rtdc_pkg::NUM_W;
  localparam int OW = rtdc_pkg::OHM_W;

  logic          v_q    [NW];
  logic [OW:0]   rem_q  [NW];
  logic [NW-1:0] work_q [NW];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_in;
    logic [OW:0]   rem_in;
    logic [NW-1:0] work_in;
    logic [OW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign work_in = dividend;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign work_in = work_q[i-1];
    end

    assign trial = {rem_in[OW-1:0], work_in[NW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? trial - {1'b0, divisor} : trial;
        work_q[i] <= {work_in[NW-2:0], ge};
      end
    end
  end

  assign out_valid = v_q[NW-1];
  assign quotient  = work_q[NW-1];

endmodule

[hw/rtl/rtdc_sqrt.sv]
module rtdc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [rtdc_pkg::DQ_W-1:0]   in_dq,
  input  rtdc_pkg::root_side_t        in_side,
  output logic [rtdc_pkg::ROOT_W-1:0] out_root,
  output rtdc_pkg::root_side_t        out_side
);

  localparam int RN = rtdc_pkg::ROOT_W;
  localparam int RW = rtdc_pkg::DQ_W + 1;

  rtdc_pkg::root_side_t side_q [RN];
  logic [RW-1:0]        rem_q  [RN];
  logic [RN-1:0]        root_q [RN];

  // floor square root, one root bit per stage, MSB first
  for (genvar i = 0; i < RN; i++) begin : g_stage
    localparam int K = RN - 1 - i;
    rtdc_pkg::root_side_t side_in;
    logic [RW-1:0]        rem_in;
    logic [RN-1:0]        root_in;
    logic [RW-1:0]        trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign side_in = in_side;
      assign rem_in  = RW'(in_dq);
      assign root_in = '0;
    end else begin : g_next
      assign side_in = side_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[i].valid <= 1'b0;
      end else if (en) begin
        side_q[i] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? rem_in - trial : rem_in;
        root_q[i] <= ge ? root_in | (RN'(1) << K) : root_in;
      end
    end
  end

  assign out_root = root_q[RN-1];
  assign out_side = side_q[RN-1];

endmodule

[hw/rtl/rtd_code_to_celsius_unit.sv]
// channel   | signals                                   | role
// ----------+-------------------------------------------+---------------------------
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data | 0 reference_ohms, 1 nominal
// code      | code_valid, code_ready, rtd_code          | one converter code per item
// result    | result_valid, result_ready, temp_q8,      | one temperature per item
//           | used_polynomial, saturated                |
//
// One item per cycle unless stalled; stages: product 1, divider 40, Horner 11, root 30,
// scaling 3, output 1. The 40-stage divider and the 28-stage square root set the depth.
// Reset clears valid bits and loads register defaults. Stall: the whole pipeline
// holds while a result waits; code_ready drops only then. cfg_ready is always high.
module rtd_code_to_celsius_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rtdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rtdc_pkg::OHM_W-1:0]            cfg_data,
  input  logic                                  code_valid,
  output logic                                  code_ready,
  input  logic [rtdc_pkg::CODE_W-1:0]           rtd_code,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [rtdc_pkg::TEMP_W-1:0]    temp_q8,
  output logic                                  used_polynomial,
  output logic                                  saturated
);

  localparam int NW  = rtdc_pkg::NUM_W;
  localparam int OW  = rtdc_pkg::OHM_W;
  localparam int HW  = rtdc_pkg::H_W;
  localparam int SP  = rtdc_pkg::SPLIT;
  localparam int RW  = rtdc_pkg::R_W;
  localparam int TW  = rtdc_pkg::TEMP_W;
  localparam int MW  = rtdc_pkg::M_W;
  localparam int GW  = rtdc_pkg::MAG_W;
  localparam int PN  = rtdc_pkg::POLY_N;
  localparam int RQW = NW + 7;

  logic en;
  assign en         = !result_valid || result_ready;
  assign code_ready = en;
  assign cfg_ready  = 1'b1;

  // configuration
  logic [OW-1:0] reference_ohms;
  logic [OW-1:0] nominal_ohms;
  logic [OW-1:0] divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms <= rtdc_pkg::REFERENCE_RESET;
      nominal_ohms   <= rtdc_pkg::NOMINAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtdc_pkg::REG_REFERENCE: reference_ohms <= cfg_data;
        rtdc_pkg::REG_NOMINAL:   nominal_ohms   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign divisor = (nominal_ohms == '0) ? OW'(1) : nominal_ohms;

  // code * reference
  logic [rtdc_pkg::PROD_W-1:0] prod;
  logic                        a_valid;
  logic [NW-1:0]               a_num;

  assign prod = rtdc_pkg::PROD_W'(rtd_code) * rtdc_pkg::PROD_W'(reference_ohms);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= code_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num <= {prod, {rtdc_pkg::PRE_SHIFT{1'b0}}};
    end
  end

  logic          x_valid;
  logic [NW-1:0] xq;

  rtdc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .dividend  (a_num),
    .divisor   (divisor),
    .out_valid (x_valid),
    .quotient  (xq)
  );

  // branch setup
  logic [RQW-1:0]        rq_full;
  logic [NW-1:0]         y_full;
  logic                  qok;
  rtdc_pkg::poly_side_t  p0_side;

  assign rq_full = RQW'(xq) * RQW'(rtdc_pkg::RQ_MUL);
  assign y_full  = xq - (NW'(1) << rtdc_pkg::XQ_FRAC);
  assign qok     = (xq >= (NW'(1) << rtdc_pkg::XQ_FRAC)) && (y_full <= NW'(rtdc_pkg::Y_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_side.valid <= 1'b0;
    end else if (en) begin
      p0_side.valid <= x_valid;
      p0_side.hi    <= |rq_full[RQW-1:RW+rtdc_pkg::RQ_SH];
      p0_side.qok   <= qok;
      p0_side.y     <= y_full[rtdc_pkg::Y_W-1:0];
      p0_side.r     <= rq_full[RW+rtdc_pkg::RQ_SH-1:rtdc_pkg::RQ_SH];
    end
  end

  // Horner, two stages per step
  rtdc_pkg::poly_side_t     hs_in [PN];
  rtdc_pkg::poly_side_t     hs_a  [PN];
  rtdc_pkg::poly_side_t     hs_b  [PN];
  logic signed [HW-1:0]     h_in  [PN];
  logic signed [HW-1:0]     h_q   [PN];
  logic signed [HW-SP+RW:0] pp_hi [PN];
  logic [SP+RW-1:0]         pp_lo [PN];

  for (genvar j = 0; j < PN; j++) begin : g_horner
    logic signed [HW-SP-1:0]         h_hi;
    logic [SP-1:0]                   h_lo;
    logic signed [rtdc_pkg::SUM_W-1:0] sum;

    if (j == 0) begin : g_first
      assign h_in[j]  = rtdc_pkg::POLY_C5;
      assign hs_in[j] = p0_side;
    end else begin : g_next
      assign h_in[j]  = h_q[j-1];
      assign hs_in[j] = hs_b[j-1];
    end

    assign h_hi = h_in[j][HW-1:SP];
    assign h_lo = h_in[j][SP-1:0];
    assign sum  = (rtdc_pkg::SUM_W'(pp_hi[j]) <<< SP)
                + $signed(rtdc_pkg::SUM_W'(pp_lo[j]));

    always_ff @(posedge clk) begin
      if (rst) begin
        hs_a[j].valid <= 1'b0;
        hs_b[j].valid <= 1'b0;
      end else if (en) begin
        hs_a[j] <= hs_in[j];
        hs_b[j] <= hs_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pp_hi[j] <= h_hi * $signed({1'b0, hs_in[j].r});
        pp_lo[j] <= h_lo * hs_in[j].r;
        h_q[j]   <= HW'(sum >>> rtdc_pkg::POLY_SH[j]) + rtdc_pkg::POLY_C[j];
      end
    end
  end

  // polynomial rounding and clamp, quadratic product
  logic signed [HW-1:0]          t_full;
  logic [TW-1:0]                 poly_t;
  logic                          poly_sat;
  rtdc_pkg::poly_side_t          hl;
  rtdc_pkg::root_side_t          rd_side;
  logic [rtdc_pkg::DQ_W-1:0]     rd_prod;

  assign hl     = hs_b[PN-1];
  assign t_full = (h_q[PN-1] + rtdc_pkg::ROUND_ADD) >>> rtdc_pkg::ROUND_SH;

  always_comb begin
    if (hl.hi) begin
      poly_t   = rtdc_pkg::TEMP_MAX;
      poly_sat = 1'b1;
    end else if (t_full > HW'(rtdc_pkg::TEMP_MAX)) begin
      poly_t   = rtdc_pkg::TEMP_MAX;
      poly_sat = 1'b1;
    end else if (t_full < HW'(rtdc_pkg::TEMP_MIN)) begin
      poly_t   = rtdc_pkg::TEMP_MIN;
      poly_sat = 1'b1;
    end else begin
      poly_t   = t_full[TW-1:0];
      poly_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_side.valid <= 1'b0;
    end else if (en) begin
      rd_side.valid    <= hl.valid;
      rd_side.qok      <= hl.qok;
      rd_side.poly_t   <= poly_t;
      rd_side.poly_sat <= poly_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_prod <= rtdc_pkg::DQ_W'(hl.y) * rtdc_pkg::DQ_W'(rtdc_pkg::FOUR_B);
    end
  end

  // discriminant
  rtdc_pkg::root_side_t      dq_side;
  logic [rtdc_pkg::DQ_W-1:0] dq_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_side.valid <= 1'b0;
    end else if (en) begin
      dq_side <= rd_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_val <= rd_side.qok ? rtdc_pkg::DQ_W'(rtdc_pkg::K_Q24) - rd_prod : '0;
    end
  end

  logic [rtdc_pkg::ROOT_W-1:0] root;
  rtdc_pkg::root_side_t        sq_side;

  rtdc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_dq    (dq_val),
    .in_side  (dq_side),
    .out_root (root),
    .out_side (sq_side)
  );

  // temp = floor((20 p 2^F + 231 2^11) / (231 2^12))
  logic [rtdc_pkg::ROOT_W-1:0] p_val;
  logic [rtdc_pkg::N_W-1:0]    n_val;
  rtdc_pkg::root_side_t        f1_side;
  rtdc_pkg::root_side_t        f2_side;
  rtdc_pkg::root_side_t        f3_side;
  logic [MW-1:0]               m1;
  logic [MW-1:0]               m2;
  logic [MW+GW-1:0]            qm;
  logic [GW-1:0]               q0;
  logic [MW-1:0]               rem;
  logic [GW-1:0]               q3;
  logic                        ge3;

  assign p_val = rtdc_pkg::A_Q12 - root;
  assign n_val = ((rtdc_pkg::N_W'(p_val) * rtdc_pkg::N_W'(rtdc_pkg::P_MUL))
                  << rtdc_pkg::FRAC_BITS) + rtdc_pkg::N_OFFSET;
  assign q0    = qm[MW+GW-1:rtdc_pkg::MAG_K];
  assign rem   = m2 - MW'(q0) * MW'(rtdc_pkg::DEN_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_side.valid <= 1'b0;
      f2_side.valid <= 1'b0;
      f3_side.valid <= 1'b0;
    end else if (en) begin
      f1_side <= sq_side;
      f2_side <= f1_side;
      f3_side <= f2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= n_val[rtdc_pkg::N_W-1:rtdc_pkg::DEN_SH];
      qm  <= (MW+GW)'(m1) * (MW+GW)'(rtdc_pkg::MAGIC);
      m2  <= m1;
      q3  <= q0;
      ge3 <= rem >= MW'(rtdc_pkg::DEN_Q);
    end
  end

  // select and output register
  logic [GW-1:0] quad_q;
  assign quad_q = q3 + GW'(ge3);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= f3_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f3_side.qok) begin
        used_polynomial <= 1'b0;
        if (quad_q > GW'(rtdc_pkg::TEMP_MAX)) begin
          temp_q8   <= rtdc_pkg::TEMP_MAX;
          saturated <= 1'b1;
        end else begin
          temp_q8   <= $signed(quad_q[TW-1:0]);
          saturated <= 1'b0;
        end
      end else begin
        used_polynomial <= 1'b1;
        temp_q8         <= $signed(f3_side.poly_t);
        saturated       <= f3_side.poly_sat;
      end
    end
  end

  a_quad_nonneg: assert property (@(posedge clk) disable iff (rst)
    result_valid && !used_polynomial |-> !temp_q8[TW-1])
    else $error("quadratic result negative");

  a_sat_rails: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> temp_q8 == rtdc_pkg::TEMP_MAX || temp_q8 == rtdc_pkg::TEMP_MIN)
    else $error("saturated result off the rails");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_side.valid && sq_side.qok |-> root <= rtdc_pkg::A_Q12)
    else $error("root exceeds A term");

endmodule
